// ===== rtl/core/lmsb_pkg.sv =====
package lmsb_pkg;

  localparam logic [1:0] ST_IDLE    = 2'd0;
  localparam logic [1:0] ST_RUNNING = 2'd1;
  localparam logic [1:0] ST_DONE    = 2'd2;
  localparam logic [1:0] ST_ERROR   = 2'd3;

  localparam logic [1:0] KIND_TICK    = 2'd0;
  localparam logic [1:0] KIND_BUS     = 2'd1;
  localparam logic [1:0] KIND_XFER    = 2'd2;
  localparam logic [1:0] KIND_BUS_ERR = 2'd3;

  localparam int unsigned PATTERN_W = 20;
  localparam int unsigned ROW_IDX_W = 3;
  localparam logic [ROW_IDX_W-1:0] ROW_LAST = 3'd4;

  localparam logic [7:0] COLUMN_BLANK = 8'h1F;
  localparam logic [7:0] ROW_BLANK    = 8'h7E;

  typedef struct packed {
    logic [1:0]           kind;
    logic [PATTERN_W-1:0] led_pattern;
    logic                 flag_start_sent;
    logic                 flag_address_sent;
    logic                 flag_byte_finished;
    logic                 flag_bus_error;
    logic                 flag_arbitration_lost;
    logic                 flag_ack_failure;
    logic                 xfer_complete;
    logic                 xfer_error;
  } lmsb_event_t;

  typedef struct packed {
    logic [1:0]           xact_state;
    logic [ROW_IDX_W-1:0] row_index;
    logic [7:0]           column_reg;
    logic [7:0]           row_reg;
  } lmsb_state_t;

  typedef struct packed {
    logic do_reinit;
    logic send_stop;
    logic send_start;
    logic send_address;
    logic xfer_channel_off;
    logic read_second_status;
    logic irq_enabled;
  } lmsb_action_t;

  // (idx + 1) mod 5 for every 3-bit index
  function automatic logic [ROW_IDX_W-1:0] row_advance(input logic [ROW_IDX_W-1:0] idx);
    logic [ROW_IDX_W-1:0] r;
    case (idx)
      3'd0:    r = 3'd1;
      3'd1:    r = 3'd2;
      3'd2:    r = 3'd3;
      3'd3:    r = 3'd4;
      3'd4:    r = 3'd0;
      3'd5:    r = 3'd1;
      3'd6:    r = 3'd2;
      3'd7:    r = 3'd3;
      default: r = 3'd0;
    endcase
    return r;
  endfunction

  // active-low row select
  function automatic logic [7:0] row_select(input logic [ROW_IDX_W-1:0] r);
    logic [7:0] b;
    case (r)
      3'd0:    b = 8'h7E;
      3'd1:    b = 8'h7D;
      3'd2:    b = 8'h7B;
      3'd3:    b = 8'h6F;
      3'd4:    b = 8'h5F;
      default: b = 8'h7E;
    endcase
    return b;
  endfunction

  // nibble bit-reversed, inverted, with bit 4 set
  function automatic logic [7:0] column_map(input logic [3:0] nib);
    return {4'h1, ~nib[0], ~nib[1], ~nib[2], ~nib[3]};
  endfunction

endpackage

// ===== rtl/core/led_matrix_scan_bus_sequencer.sv =====
// Channel  Direction  Handshake            Payload
// in       input      in_valid/in_ready    kind, led_pattern, bus and transfer flags
// out      output     out_valid/out_ready  action flags, column_byte, row_byte, bus_state
//
// One event enters per cycle while the output is not stalled; its result reaches the outputs
// through the input register, then the result register.
// The scan state advances as an event moves from the input register into the result register.
// Reset (rst, synchronous) empties both stages and loads idle state, row 0, bytes 0x1F / 0x7E.
// A stalled output holds; the input register still takes one more event while the result waits.
module led_matrix_scan_bus_sequencer
  import lmsb_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           kind,
  input  logic [PATTERN_W-1:0] led_pattern,
  input  logic                 flag_start_sent,
  input  logic                 flag_address_sent,
  input  logic                 flag_byte_finished,
  input  logic                 flag_bus_error,
  input  logic                 flag_arbitration_lost,
  input  logic                 flag_ack_failure,
  input  logic                 xfer_complete,
  input  logic                 xfer_error,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 do_reinit,
  output logic                 send_stop,
  output logic                 send_start,
  output logic                 send_address,
  output logic                 xfer_channel_off,
  output logic                 read_second_status,
  output logic                 irq_enabled,
  output logic [7:0]           column_byte,
  output logic [7:0]           row_byte,
  output logic [1:0]           bus_state
);

  lmsb_event_t  ev_reg;
  logic         ev_valid;
  lmsb_state_t  scan;
  lmsb_state_t  scan_next;
  lmsb_action_t act_next;
  lmsb_action_t act;
  logic         out_free;
  logic         ev_move;

  assign out_free = !out_valid || out_ready;
  assign ev_move  = ev_valid && out_free;
  assign in_ready = !ev_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      ev_valid <= 1'b0;
    end else if (in_ready) begin
      ev_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      ev_reg <= '{kind, led_pattern, flag_start_sent, flag_address_sent,
                  flag_byte_finished, flag_bus_error, flag_arbitration_lost,
                  flag_ack_failure, xfer_complete, xfer_error};
    end
  end

  lmsb_step u_step (
    .ev  (ev_reg),
    .cur (scan),
    .nxt (scan_next),
    .act (act_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      scan      <= '{ST_IDLE, '0, COLUMN_BLANK, ROW_BLANK};
      out_valid <= 1'b0;
    end else begin
      if (ev_move) begin
        scan <= scan_next;
      end
      if (out_free) begin
        out_valid <= ev_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ev_move) begin
      act <= act_next;
    end
  end

  assign do_reinit          = act.do_reinit;
  assign send_stop          = act.send_stop;
  assign send_start         = act.send_start;
  assign send_address       = act.send_address;
  assign xfer_channel_off   = act.xfer_channel_off;
  assign read_second_status = act.read_second_status;
  assign irq_enabled        = act.irq_enabled;
  assign column_byte        = scan.column_reg;
  assign row_byte           = scan.row_reg;
  assign bus_state          = scan.xact_state;

`ifndef SYNTHESIS
  a_row_in_range: assert property (@(posedge clk) disable iff (rst)
    scan.row_index <= ROW_LAST)
    else $error("row index out of range");

  a_start_runs: assert property (@(posedge clk) disable iff (rst)
    out_valid && send_start |-> bus_state == ST_RUNNING && irq_enabled)
    else $error("start without running state");

  a_stop_no_irq: assert property (@(posedge clk) disable iff (rst)
    out_valid && send_stop |-> !irq_enabled)
    else $error("stop with interrupts enabled");

  a_reinit_blank: assert property (@(posedge clk) disable iff (rst)
    out_valid && do_reinit |-> bus_state == ST_IDLE && column_byte == COLUMN_BLANK
      && row_byte == ROW_BLANK)
    else $error("reinit left bytes loaded");

  a_move_delivers: assert property (@(posedge clk) disable iff (rst)
    ev_move |=> out_valid)
    else $error("event dropped between stages");
`endif

endmodule

// ===== rtl/core/lmsb_step.sv =====
module lmsb_step
  import lmsb_pkg::*;
(
  input  lmsb_event_t  ev,
  input  lmsb_state_t  cur,
  output lmsb_state_t  nxt,
  output lmsb_action_t act
);

  logic [ROW_IDX_W-1:0] r;
  logic [3:0]           nib;

  assign r = row_advance(cur.row_index);

  always_comb begin
    case (r)
      3'd0:    nib = ev.led_pattern[3:0];
      3'd1:    nib = ev.led_pattern[7:4];
      3'd2:    nib = ev.led_pattern[11:8];
      3'd3:    nib = ev.led_pattern[15:12];
      3'd4:    nib = ev.led_pattern[19:16];
      default: nib = ev.led_pattern[3:0];
    endcase
  end

  always_comb begin
    nxt = cur;
    act = '0;
    case (ev.kind)
      KIND_TICK: begin
        if (cur.xact_state == ST_ERROR) begin
          act.do_reinit  = 1'b1;
          nxt.xact_state = ST_IDLE;
          nxt.column_reg = COLUMN_BLANK;
          nxt.row_reg    = ROW_BLANK;
        end else if (cur.xact_state != ST_IDLE) begin
          nxt.xact_state = ST_ERROR;
          act.send_stop  = 1'b1;
        end else begin
          nxt.row_index        = r;
          nxt.column_reg       = column_map(nib);
          nxt.row_reg          = row_select(r);
          act.xfer_channel_off = 1'b1;
          act.send_start       = 1'b1;
          nxt.xact_state       = ST_RUNNING;
          act.irq_enabled      = 1'b1;
        end
      end
      KIND_BUS: begin
        act.read_second_status = ev.flag_address_sent;
        if (ev.flag_bus_error || ev.flag_arbitration_lost || ev.flag_ack_failure) begin
          nxt.xact_state = ST_ERROR;
          act.send_stop  = 1'b1;
        end else if (ev.flag_byte_finished) begin
          nxt.xact_state = ST_IDLE;
          act.send_stop  = 1'b1;
        end else begin
          act.send_address = ev.flag_start_sent;
          act.irq_enabled  = 1'b1;
        end
      end
      KIND_XFER: begin
        if (ev.xfer_complete) begin
          act.xfer_channel_off = 1'b1;
          nxt.xact_state       = ST_DONE;
        end
        if (ev.xfer_error) begin
          act.send_stop  = 1'b1;
          nxt.xact_state = ST_ERROR;
        end else begin
          act.irq_enabled = 1'b1;
        end
      end
      default: begin
        nxt.xact_state = ST_ERROR;
        act.send_stop  = 1'b1;
      end
    endcase
  end

endmodule

// ===== dv/tb_led_matrix_scan_bus_sequencer.sv =====
`timescale 1ns / 100ps

module tb_led_matrix_scan_bus_sequencer;
  import lmsb_pkg::*;

  localparam int unsigned HOLD_CYCLES    = 200;
  localparam int unsigned WATCHDOG_LIMIT = 3000;
  localparam int unsigned DRAIN_CYCLES   = 8;

  typedef struct packed {
    lmsb_action_t act;
    logic [7:0]   column_byte;
    logic [7:0]   row_byte;
    logic [1:0]   bus_state;
  } scan_result_t;

  class scan_scoreboard;
    logic [1:0]           xact_state;
    logic [ROW_IDX_W-1:0] row_index;
    logic [7:0]           column_reg;
    logic [7:0]           row_reg;
    scan_result_t         pending_results[$];
    int unsigned          errors;

    function new();
      xact_state = ST_IDLE;
      row_index  = '0;
      column_reg = COLUMN_BLANK;
      row_reg    = ROW_BLANK;
      errors     = 0;
    endfunction

    function logic [7:0] column_drive(logic [3:0] nib);
      logic [7:0] b;
      case (nib)
        4'h0: b = 8'h1f;  4'h1: b = 8'h17;  4'h2: b = 8'h1b;  4'h3: b = 8'h13;
        4'h4: b = 8'h1d;  4'h5: b = 8'h15;  4'h6: b = 8'h19;  4'h7: b = 8'h11;
        4'h8: b = 8'h1e;  4'h9: b = 8'h16;  4'ha: b = 8'h1a;  4'hb: b = 8'h12;
        4'hc: b = 8'h1c;  4'hd: b = 8'h14;  4'he: b = 8'h18;  default: b = 8'h10;
      endcase
      return b;
    endfunction

    function logic [7:0] row_drive(logic [ROW_IDX_W-1:0] r);
      logic [7:0] b;
      case (r)
        3'd0: b = 8'h7e;
        3'd1: b = 8'h7d;
        3'd2: b = 8'h7b;
        3'd3: b = 8'h6f;
        default: b = 8'h5f;
      endcase
      return b;
    endfunction

    // advance the scan state by one event and return what the block reports
    function scan_result_t scan_step(lmsb_event_t ev);
      scan_result_t r;
      int unsigned  nxt;
      r = '0;
      case (ev.kind)
        KIND_TICK: begin
          if (xact_state == ST_ERROR) begin
            r.act.do_reinit = 1'b1;
            xact_state = ST_IDLE;
            column_reg = COLUMN_BLANK;
            row_reg    = ROW_BLANK;
          end else if (xact_state != ST_IDLE) begin
            xact_state = ST_ERROR;
            r.act.send_stop = 1'b1;
          end else begin
            nxt = (int'(row_index) + 1) % 5;
            row_index  = ROW_IDX_W'(nxt);
            column_reg = column_drive(4'(ev.led_pattern >> (4 * nxt)));
            row_reg    = row_drive(row_index);
            r.act.xfer_channel_off = 1'b1;
            r.act.send_start       = 1'b1;
            r.act.irq_enabled      = 1'b1;
            xact_state = ST_RUNNING;
          end
        end
        KIND_BUS: begin
          r.act.read_second_status = ev.flag_address_sent;
          if (ev.flag_bus_error || ev.flag_arbitration_lost || ev.flag_ack_failure) begin
            xact_state = ST_ERROR;
            r.act.send_stop = 1'b1;
          end else if (ev.flag_byte_finished) begin
            xact_state = ST_IDLE;
            r.act.send_stop = 1'b1;
          end else begin
            r.act.send_address = ev.flag_start_sent;
            r.act.irq_enabled  = 1'b1;
          end
        end
        KIND_XFER: begin
          if (ev.xfer_complete) begin
            r.act.xfer_channel_off = 1'b1;
            xact_state = ST_DONE;
          end
          if (ev.xfer_error) begin
            r.act.send_stop = 1'b1;
            xact_state = ST_ERROR;
          end else begin
            r.act.irq_enabled = 1'b1;
          end
        end
        default: begin
          xact_state = ST_ERROR;
          r.act.send_stop = 1'b1;
        end
      endcase
      r.column_byte = column_reg;
      r.row_byte    = row_reg;
      r.bus_state   = xact_state;
      return r;
    endfunction

    function void note_input(lmsb_event_t ev);
      pending_results.push_back(scan_step(ev));
    endfunction

    function void compare(string name, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
    endfunction

    function void check_result(scan_result_t got);
      scan_result_t want;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: result with nothing outstanding, expected none, actual %h", $time, got);
        return;
      end
      want = pending_results.pop_front();
      compare("do_reinit", 8'(want.act.do_reinit), 8'(got.act.do_reinit));
      compare("send_stop", 8'(want.act.send_stop), 8'(got.act.send_stop));
      compare("send_start", 8'(want.act.send_start), 8'(got.act.send_start));
      compare("send_address", 8'(want.act.send_address), 8'(got.act.send_address));
      compare("xfer_channel_off", 8'(want.act.xfer_channel_off),
              8'(got.act.xfer_channel_off));
      compare("read_second_status", 8'(want.act.read_second_status),
              8'(got.act.read_second_status));
      compare("irq_enabled", 8'(want.act.irq_enabled), 8'(got.act.irq_enabled));
      compare("column_byte", want.column_byte, got.column_byte);
      compare("row_byte", want.row_byte, got.row_byte);
      compare("bus_state", 8'(want.bus_state), 8'(got.bus_state));
    endfunction

    function int unsigned outstanding();
      return pending_results.size();
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [1:0]           kind = KIND_TICK;
  logic [PATTERN_W-1:0] led_pattern = '0;
  logic                 flag_start_sent = 1'b0;
  logic                 flag_address_sent = 1'b0;
  logic                 flag_byte_finished = 1'b0;
  logic                 flag_bus_error = 1'b0;
  logic                 flag_arbitration_lost = 1'b0;
  logic                 flag_ack_failure = 1'b0;
  logic                 xfer_complete = 1'b0;
  logic                 xfer_error = 1'b0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic                 do_reinit;
  logic                 send_stop;
  logic                 send_start;
  logic                 send_address;
  logic                 xfer_channel_off;
  logic                 read_second_status;
  logic                 irq_enabled;
  logic [7:0]           column_byte;
  logic [7:0]           row_byte;
  logic [1:0]           bus_state;

  scan_scoreboard sb = new();
  int unsigned    tx_idle_pct = 35;
  int unsigned    rx_idle_pct = 35;
  bit             rx_hold_req = 1'b0;
  int unsigned    items_sent = 0;
  int unsigned    quiet_cycles = 0;

  led_matrix_scan_bus_sequencer u_dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver: random backpressure, plus one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // sample both channels and guard against a hang
  always @(posedge clk) begin
    lmsb_event_t  ev;
    scan_result_t res;
    if (rst) begin
      quiet_cycles <= 0;
    end else begin
      if (in_valid && in_ready) begin
        ev.kind                  = kind;
        ev.led_pattern           = led_pattern;
        ev.flag_start_sent       = flag_start_sent;
        ev.flag_address_sent     = flag_address_sent;
        ev.flag_byte_finished    = flag_byte_finished;
        ev.flag_bus_error        = flag_bus_error;
        ev.flag_arbitration_lost = flag_arbitration_lost;
        ev.flag_ack_failure      = flag_ack_failure;
        ev.xfer_complete         = xfer_complete;
        ev.xfer_error            = xfer_error;
        sb.note_input(ev);
      end
      if (out_valid && out_ready) begin
        res.act.do_reinit          = do_reinit;
        res.act.send_stop          = send_stop;
        res.act.send_start         = send_start;
        res.act.send_address       = send_address;
        res.act.xfer_channel_off   = xfer_channel_off;
        res.act.read_second_status = read_second_status;
        res.act.irq_enabled        = irq_enabled;
        res.column_byte            = column_byte;
        res.row_byte               = row_byte;
        res.bus_state              = bus_state;
        sb.check_result(res);
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // idle cycle by cycle so the sender is quiet in about tx_idle_pct of cycles
  function automatic int unsigned draw_gap();
    int unsigned gap;
    gap = 0;
    while ($urandom_range(99) < tx_idle_pct) gap++;
    return gap;
  endfunction

  // bus flags packed as {start, address, byte_finished, bus_error, arb_lost, ack_fail}
  function automatic lmsb_event_t mk(logic [1:0] k, logic [PATTERN_W-1:0] pat,
                                     logic [5:0] bus_flags, logic [1:0] xfer_flags);
    lmsb_event_t ev;
    ev.kind                  = k;
    ev.led_pattern           = pat;
    ev.flag_start_sent       = bus_flags[5];
    ev.flag_address_sent     = bus_flags[4];
    ev.flag_byte_finished    = bus_flags[3];
    ev.flag_bus_error        = bus_flags[2];
    ev.flag_arbitration_lost = bus_flags[1];
    ev.flag_ack_failure      = bus_flags[0];
    ev.xfer_complete         = xfer_flags[1];
    ev.xfer_error            = xfer_flags[0];
    return ev;
  endfunction

  function automatic lmsb_event_t rand_event(logic [1:0] k);
    return mk(k, PATTERN_W'($urandom()), 6'($urandom()), 2'($urandom()));
  endfunction

  task automatic send_item(lmsb_event_t ev);
    int unsigned gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid              <= 1'b1;
    kind                  <= ev.kind;
    led_pattern           <= ev.led_pattern;
    flag_start_sent       <= ev.flag_start_sent;
    flag_address_sent     <= ev.flag_address_sent;
    flag_byte_finished    <= ev.flag_byte_finished;
    flag_bus_error        <= ev.flag_bus_error;
    flag_arbitration_lost <= ev.flag_arbitration_lost;
    flag_ack_failure      <= ev.flag_ack_failure;
    xfer_complete         <= ev.xfer_complete;
    xfer_error            <= ev.xfer_error;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  // one scan message, a broken one, or a burst of noise
  task automatic send_scan_group();
    lmsb_event_t msg[5];
    int unsigned pick;
    int unsigned n;
    pick = $urandom_range(99);
    if (pick < 15) begin
      n = $urandom_range(1, 3);
      repeat (n) send_item(rand_event(2'($urandom_range(3))));
      return;
    end
    // bring the machine back to idle first so the message gets through
    if (sb.xact_state == ST_ERROR) begin
      send_item(mk(KIND_TICK, PATTERN_W'($urandom()), 6'($urandom()), 2'($urandom())));
    end else if (sb.xact_state != ST_IDLE) begin
      msg[0] = rand_event(KIND_BUS);
      msg[0].flag_byte_finished    = 1'b1;
      msg[0].flag_bus_error        = 1'b0;
      msg[0].flag_arbitration_lost = 1'b0;
      msg[0].flag_ack_failure      = 1'b0;
      send_item(msg[0]);
    end
    msg[0] = rand_event(KIND_TICK);
    msg[1] = rand_event(KIND_BUS);
    msg[1].flag_start_sent       = 1'b1;
    msg[1].flag_address_sent     = 1'b0;
    msg[1].flag_byte_finished    = 1'b0;
    msg[1].flag_bus_error        = 1'b0;
    msg[1].flag_arbitration_lost = 1'b0;
    msg[1].flag_ack_failure      = 1'b0;
    msg[2] = msg[1];
    msg[2].flag_start_sent   = 1'b0;
    msg[2].flag_address_sent = 1'b1;
    msg[2].led_pattern       = PATTERN_W'($urandom());
    msg[2].xfer_complete     = 1'($urandom());
    msg[2].xfer_error        = 1'($urandom());
    msg[3] = rand_event(KIND_XFER);
    msg[3].xfer_complete = 1'b1;
    msg[3].xfer_error    = 1'b0;
    msg[4] = rand_event(KIND_BUS);
    msg[4].flag_byte_finished    = 1'b1;
    msg[4].flag_bus_error        = 1'b0;
    msg[4].flag_arbitration_lost = 1'b0;
    msg[4].flag_ack_failure      = 1'b0;
    if (pick < 30) msg[$urandom_range(4)] = rand_event(2'($urandom_range(3)));
    n = (pick < 22) ? $urandom_range(1, 5) : 5;
    for (int i = 0; i < n; i++) send_item(msg[i]);
  endtask

  task automatic run_random(int unsigned count);
    int unsigned stop_at;
    stop_at = items_sent + count;
    while (items_sent < stop_at) send_scan_group();
  endtask

  // let the monitor note the last transfer before looking at the queue
  task automatic wait_drained();
    @(posedge clk);
    while (sb.outstanding() != 0) @(posedge clk);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: every event kind from the states that matter, row wrap, pattern extremes
    send_item(mk(KIND_TICK, 20'hFFFFF, 6'b000000, 2'b00));
    send_item(mk(KIND_TICK, 20'h00000, 6'b111111, 2'b11));  // tick while running
    send_item(mk(KIND_TICK, 20'hFFFFF, 6'b000000, 2'b00));  // tick in error: reinit
    send_item(mk(KIND_TICK, 20'h00000, 6'b000000, 2'b00));
    send_item(mk(KIND_BUS, 20'h00000, 6'b110000, 2'b11));
    send_item(mk(KIND_BUS, 20'hFFFFF, 6'b000000, 2'b00));
    send_item(mk(KIND_BUS, 20'h00000, 6'b001100, 2'b00));
    send_item(mk(KIND_TICK, 20'h00000, 6'b000000, 2'b00));
    send_item(mk(KIND_BUS_ERR, 20'hFFFFF, 6'b111111, 2'b11));
    send_item(mk(KIND_TICK, 20'h00000, 6'b000000, 2'b00));
    send_item(mk(KIND_TICK, 20'hA5C3F, 6'b000000, 2'b00));
    send_item(mk(KIND_XFER, 20'h00000, 6'b111111, 2'b10));
    send_item(mk(KIND_TICK, 20'h00000, 6'b000000, 2'b00));  // tick in transfer done
    send_item(mk(KIND_TICK, 20'h00000, 6'b000000, 2'b00));
    send_item(mk(KIND_TICK, 20'h12345, 6'b000000, 2'b00));
    send_item(mk(KIND_XFER, 20'h00000, 6'b000000, 2'b11));
    send_item(mk(KIND_TICK, 20'h00000, 6'b000000, 2'b00));
    send_item(mk(KIND_TICK, 20'h5A5A5, 6'b000000, 2'b00));  // row wraps to 0
    send_item(mk(KIND_BUS, 20'h00000, 6'b010010, 2'b00));
    send_item(mk(KIND_TICK, 20'h00000, 6'b000000, 2'b00));
    send_item(mk(KIND_TICK, 20'h0F0F0, 6'b000000, 2'b00));
    send_item(mk(KIND_BUS, 20'h00000, 6'b000001, 2'b00));
    send_item(mk(KIND_TICK, 20'h00000, 6'b000000, 2'b00));
    send_item(mk(KIND_BUS, 20'h00000, 6'b101000, 2'b00));   // byte finished wins over start
    send_item(mk(KIND_XFER, 20'hFFFFF, 6'b111111, 2'b00));

    run_random(300);

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    run_random(200);

    // fill the block behind a long receiver hold-off
    rx_hold_req = 1'b1;
    run_random(30);
    tx_idle_pct = 35;
    rx_idle_pct = 35;

    in_valid <= 1'b0;
    wait_drained();
    @(posedge clk);
    run_random(330);

    in_valid <= 1'b0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/lmsb_pkg.sv
rtl/core/lmsb_step.sv
rtl/core/led_matrix_scan_bus_sequencer.sv
dv/tb_led_matrix_scan_bus_sequencer.sv
